// File: sv/oriented_box_corners_assert.svh
// ----------------------------------------------------------------------------
// oriented box corners assertion macros
// shared property wrappers on the block clock and reset
// ----------------------------------------------------------------------------
`ifndef ORIENTED_BOX_CORNERS_ASSERT_SVH
`define ORIENTED_BOX_CORNERS_ASSERT_SVH

// same-cycle implication
`define OBC_ASSERT_NOW(name, cond, res, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (res)) \
        else $error(msg);

// next-cycle implication
`define OBC_ASSERT_NEXT(name, cond, res, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (res)) \
        else $error(msg);

`endif

// File: sv/obc_pkg.sv
// ----------------------------------------------------------------------------
// obc_pkg
// types, widths and helper functions of the oriented box corners block
// ----------------------------------------------------------------------------
package obc_pkg;

    localparam int CB   = 32;           // coordinate width
    localparam int WB   = 20;           // width field bits
    localparam int WD   = CB + 1;       // magnitude of a coordinate difference
    localparam int WL   = 2 * WD + 1;   // squared length
    localparam int WM   = WB + WD;      // width times difference
    localparam int WML  = (WM + 1) / 2; // low part of the split square
    localparam int WMH  = WM - WML;
    localparam int WP   = 112;          // wide products of the search
    localparam int WS   = CB + 2;       // corner sum before clamping
    localparam int NS   = WB;           // search steps, one per result bit

    typedef struct packed {
        logic signed [CB-1:0] fx;
        logic signed [CB-1:0] fy;
        logic signed [CB-1:0] rx;
        logic signed [CB-1:0] ry;
        logic                 neg_fdx;
        logic                 neg_fdy;
        logic                 neg_rdx;
        logic                 neg_rdy;
        logic                 vert;
        logic                 horz;
        logic [WB-1:0]        half;
    } t_ctx;

    typedef struct packed {
        logic [WB-1:0] k;
        logic [WP-1:0] k2l;   // k^2 * len^2
        logic [WP-1:0] kl;    // k * len^2
    } t_lane;

    typedef struct packed {
        t_ctx          ctx;
        logic [WP-1:0] l2;
        logic [WP-1:0] lim_x;
        logic [WP-1:0] lim_y;
        t_lane         lx;
        t_lane         ly;
    } t_srch;

    // one bit of the offset search: keep the bit if c <= half and (2c-1)^2 * len^2 <= lim
    function automatic t_lane search_step(t_lane a, logic [WP-1:0] l2,
                                          logic [WP-1:0] lim, logic [WB-1:0] half,
                                          int b);
        t_lane         r;
        logic [WB-1:0] c;
        logic [WP-1:0] c2l;
        logic [WP-1:0] cl;
        logic [WP-1:0] m2l;
        c   = a.k | (WB'(1) << b);
        c2l = a.k2l + (a.kl << (b + 1)) + (l2 << (2 * b));
        cl  = a.kl + (l2 << b);
        m2l = (c2l << 2) - (cl << 2) + l2;
        r   = a;
        if ((c <= half) && (m2l <= lim)) begin
            r.k   = c;
            r.k2l = c2l;
            r.kl  = cl;
        end
        return r;
    endfunction

    function automatic logic signed [CB-1:0] sat(logic signed [WS-1:0] v);
        logic signed [WS-1:0] hi;
        logic signed [WS-1:0] lo;
        hi = WS'((64'sd1 <<< (CB - 1)) - 64'sd1);
        lo = -(WS'(64'sd1 <<< (CB - 1)));
        if (v > hi) begin
            return hi[CB-1:0];
        end else if (v < lo) begin
            return lo[CB-1:0];
        end
        return v[CB-1:0];
    endfunction

endpackage

// File: sv/oriented_box_corners.sv
// ----------------------------------------------------------------------------
// oriented_box_corners
// corners and axis-aligned bounding box of an oriented vehicle rectangle
// ----------------------------------------------------------------------------
// usage
//   input channel: front/rear centre points and full width, one transaction
//   per vehicle sample, taken when i_in_valid is high and o_in_stall is low
//   output channel: four corners and the bounding box, one transaction per
//   input, taken when o_out_valid is high and i_out_stall is low
//   throughput: one transaction per cycle unless the receiver stalls; set by
//   the 20-stage bit search of the perpendicular offsets, one result bit per
//   register stage, run for both offsets side by side
//   the search compares (2k-1)^2 * len^2 against (w * |d|)^2 using only
//   shifted adds of running products, so no root or divider is needed
//   reset (synchronous, active low) clears every stage valid bit; no item is
//   held over
//   when the receiver stalls with a result waiting, the whole pipeline holds
//   and o_in_stall rises in the same cycle; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module oriented_box_corners (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [obc_pkg::CB-1:0] i_front_x,
    input  logic signed [obc_pkg::CB-1:0] i_front_y,
    input  logic signed [obc_pkg::CB-1:0] i_rear_x,
    input  logic signed [obc_pkg::CB-1:0] i_rear_y,
    input  logic        [obc_pkg::WB-1:0] i_box_width,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [obc_pkg::CB-1:0] o_front_right_x,
    output logic signed [obc_pkg::CB-1:0] o_front_right_y,
    output logic signed [obc_pkg::CB-1:0] o_front_left_x,
    output logic signed [obc_pkg::CB-1:0] o_front_left_y,
    output logic signed [obc_pkg::CB-1:0] o_rear_left_x,
    output logic signed [obc_pkg::CB-1:0] o_rear_left_y,
    output logic signed [obc_pkg::CB-1:0] o_rear_right_x,
    output logic signed [obc_pkg::CB-1:0] o_rear_right_y,
    output logic signed [obc_pkg::CB-1:0] o_box_min_x,
    output logic signed [obc_pkg::CB-1:0] o_box_max_x,
    output logic signed [obc_pkg::CB-1:0] o_box_min_y,
    output logic signed [obc_pkg::CB-1:0] o_box_max_y
);
    import obc_pkg::*;

    `include "oriented_box_corners_assert.svh"

    // one enable for the whole pipe: it moves unless a result is held
    logic en;
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // stage 1: input register
    logic                 r_v1;
    logic signed [CB-1:0] r_fx, r_fy, r_rx, r_ry;
    logic [WB-1:0]        r_w1;

    // stage 2: differences, magnitudes, sign rules
    logic                 r_v2;
    t_ctx                 r_ctx2, n_ctx2;
    logic [WD-1:0]        r_adx, r_ady, n_adx, n_ady;
    logic [WB-1:0]        r_w2;

    // stage 3: squares and width products
    logic                 r_v3;
    t_ctx                 r_ctx3;
    logic [WL-2:0]        r_nx2, r_ny2;
    logic [WM-1:0]        r_px, r_py;

    // stage 4: squared length and split partial products of the limits
    logic                 r_v4;
    t_ctx                 r_ctx4;
    logic [WL-1:0]        r_l2;
    logic [2*WMH-1:0]     r_xhh, r_yhh;
    logic [WM-1:0]        r_xhl, r_yhl;
    logic [2*WML-1:0]     r_xll, r_yll;

    // stages 5..25: search (entry 0 holds the assembled limits)
    logic                 r_sv [0:NS];
    t_srch                r_srch [0:NS];
    t_srch                n_srch0;

    // corner stage
    logic                 r_vc;
    logic signed [CB-1:0] r_cx [0:3];
    logic signed [CB-1:0] r_cy [0:3];
    logic signed [CB-1:0] n_cx [0:3];
    logic signed [CB-1:0] n_cy [0:3];

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_sv[0]     <= 1'b0;
            r_vc        <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= i_in_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_sv[0]     <= r_v4;
            r_vc        <= r_sv[NS];
            o_out_valid <= r_vc;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx <= i_front_x;
            r_fy <= i_front_y;
            r_rx <= i_rear_x;
            r_ry <= i_rear_y;
            r_w1 <= i_box_width;
        end
    end

    // stage 2
    always_comb begin
        logic signed [WD-1:0] ddx;
        logic signed [WD-1:0] ddy;
        ddx = WD'(r_rx) - WD'(r_fx);
        ddy = WD'(r_ry) - WD'(r_fy);
        n_adx = ddx[WD-1] ? WD'(-ddx) : WD'(ddx);
        n_ady = ddy[WD-1] ? WD'(-ddy) : WD'(ddy);
        n_ctx2.fx      = r_fx;
        n_ctx2.fy      = r_fy;
        n_ctx2.rx      = r_rx;
        n_ctx2.ry      = r_ry;
        n_ctx2.neg_fdx = r_ry > r_fy;
        n_ctx2.neg_fdy = r_rx < r_fx;
        n_ctx2.neg_rdx = r_fy > r_ry;
        n_ctx2.neg_rdy = r_fx < r_rx;
        n_ctx2.vert    = (n_adx == '0);
        n_ctx2.horz    = (n_ady == '0);
        n_ctx2.half    = WB'(({1'b0, r_w1} + (WB+1)'(1)) >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx2 <= n_ctx2;
            r_adx  <= n_adx;
            r_ady  <= n_ady;
            r_w2   <= r_w1;
        end
    end

    // stage 3: the x offset uses |dy| as numerator, the y offset |dx|
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx3 <= r_ctx2;
            r_nx2  <= (WL-1)'(r_adx) * (WL-1)'(r_adx);
            r_ny2  <= (WL-1)'(r_ady) * (WL-1)'(r_ady);
            r_px   <= WM'(r_w2) * WM'(r_ady);
            r_py   <= WM'(r_w2) * WM'(r_adx);
        end
    end

    // stage 4
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx4 <= r_ctx3;
            r_l2   <= WL'(r_nx2) + WL'(r_ny2);
            r_xhh  <= (2*WMH)'(r_px[WM-1:WML]) * (2*WMH)'(r_px[WM-1:WML]);
            r_yhh  <= (2*WMH)'(r_py[WM-1:WML]) * (2*WMH)'(r_py[WM-1:WML]);
            r_xhl  <= WM'(r_px[WM-1:WML]) * WM'(r_px[WML-1:0]);
            r_yhl  <= WM'(r_py[WM-1:WML]) * WM'(r_py[WML-1:0]);
            r_xll  <= (2*WML)'(r_px[WML-1:0]) * (2*WML)'(r_px[WML-1:0]);
            r_yll  <= (2*WML)'(r_py[WML-1:0]) * (2*WML)'(r_py[WML-1:0]);
        end
    end

    // stage 5: assemble the squared limits, start the search at zero
    always_comb begin
        n_srch0.ctx   = r_ctx4;
        n_srch0.l2    = WP'(r_l2);
        n_srch0.lim_x = (WP'(r_xhh) << (2 * WML)) + (WP'(r_xhl) << (WML + 1))
                        + WP'(r_xll);
        n_srch0.lim_y = (WP'(r_yhh) << (2 * WML)) + (WP'(r_yhl) << (WML + 1))
                        + WP'(r_yll);
        n_srch0.lx    = '0;
        n_srch0.ly    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_srch[0] <= n_srch0;
        end
    end

    // search stages, most significant bit first
    for (genvar j = 1; j <= NS; j++) begin : g_srch
        t_srch n_srch;

        always_comb begin
            n_srch    = r_srch[j-1];
            n_srch.lx = search_step(r_srch[j-1].lx, r_srch[j-1].l2, r_srch[j-1].lim_x,
                                    r_srch[j-1].ctx.half, NS - j);
            n_srch.ly = search_step(r_srch[j-1].ly, r_srch[j-1].l2, r_srch[j-1].lim_y,
                                    r_srch[j-1].ctx.half, NS - j);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j] <= 1'b0;
            end else if (en) begin
                r_sv[j] <= r_sv[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_srch[j] <= n_srch;
            end
        end
    end

    // corner stage: special cases, signs, clamping
    always_comb begin
        t_ctx                 c;
        logic [WB-1:0]        ox;
        logic [WB-1:0]        oy;
        logic signed [WS-1:0] fdx, fdy, rdx, rdy;
        c = r_srch[NS].ctx;
        priority if (c.vert) begin
            ox = c.half;
            oy = '0;
        end else if (c.horz) begin
            ox = '0;
            oy = c.half;
        end else begin
            ox = r_srch[NS].lx.k;
            oy = r_srch[NS].ly.k;
        end
        fdx = c.neg_fdx ? -WS'(ox) : WS'(ox);
        fdy = c.neg_fdy ? -WS'(oy) : WS'(oy);
        rdx = c.neg_rdx ? -WS'(ox) : WS'(ox);
        rdy = c.neg_rdy ? -WS'(oy) : WS'(oy);
        n_cx[0] = sat(WS'(c.fx) + fdx);
        n_cy[0] = sat(WS'(c.fy) + fdy);
        n_cx[1] = sat(WS'(c.fx) - fdx);
        n_cy[1] = sat(WS'(c.fy) - fdy);
        n_cx[2] = sat(WS'(c.rx) + rdx);
        n_cy[2] = sat(WS'(c.ry) + rdy);
        n_cx[3] = sat(WS'(c.rx) - rdx);
        n_cy[3] = sat(WS'(c.ry) - rdy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
        end
    end

    // output stage: bounding box over the clamped corners
    always_ff @(posedge i_clk) begin
        logic signed [CB-1:0] mnx, mxx, mny, mxy;
        mnx = r_cx[0];
        mxx = r_cx[0];
        mny = r_cy[0];
        mxy = r_cy[0];
        for (int i = 1; i < 4; i++) begin
            if (r_cx[i] < mnx) mnx = r_cx[i];
            if (r_cx[i] > mxx) mxx = r_cx[i];
            if (r_cy[i] < mny) mny = r_cy[i];
            if (r_cy[i] > mxy) mxy = r_cy[i];
        end
        if (en) begin
            o_front_right_x <= r_cx[0];
            o_front_right_y <= r_cy[0];
            o_front_left_x  <= r_cx[1];
            o_front_left_y  <= r_cy[1];
            o_rear_left_x   <= r_cx[2];
            o_rear_left_y   <= r_cy[2];
            o_rear_right_x  <= r_cx[3];
            o_rear_right_y  <= r_cy[3];
            o_box_min_x     <= mnx;
            o_box_max_x     <= mxx;
            o_box_min_y     <= mny;
            o_box_max_y     <= mxy;
        end
    end

    // checks
    `OBC_ASSERT_NOW(a_k_within_half, r_sv[NS],
        (r_srch[NS].lx.k <= r_srch[NS].ctx.half) && (r_srch[NS].ly.k <= r_srch[NS].ctx.half),
        "offset search exceeded half width")
    `OBC_ASSERT_NEXT(a_search_advance, r_sv[0] && en, r_sv[1],
        "search stage lost a transaction")
    `OBC_ASSERT_NOW(a_box_order, o_out_valid,
        (o_box_min_x <= o_box_max_x) && (o_box_min_y <= o_box_max_y),
        "bounding box inverted")
    `OBC_ASSERT_NOW(a_box_holds_corners, o_out_valid,
        (o_box_min_x <= o_front_right_x) && (o_box_max_x >= o_rear_right_x) &&
        (o_box_min_y <= o_front_left_y) && (o_box_max_y >= o_rear_left_y),
        "corner outside bounding box")

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the oriented box corners block against an own prediction of the
// corners and bounding box: directed corner cases, random vehicles, random
// idling on both channels and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb;

    import obc_pkg::*;

    typedef struct {
        logic signed [CB-1:0] v [12];
    } t_box;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic signed [CB-1:0] i_front_x = '0;
    logic signed [CB-1:0] i_front_y = '0;
    logic signed [CB-1:0] i_rear_x = '0;
    logic signed [CB-1:0] i_rear_y = '0;
    logic        [WB-1:0] i_box_width = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [CB-1:0] o_res [12];

    t_box expected_boxes [$];
    int   n_errors = 0;
    bit   sender_idle = 1'b1;   // random gaps on the input side
    bit   receiver_idle = 1'b1; // random stalls on the output side
    int   hold_off = 0;         // long receiver hold-off, in cycles

    always #5 i_clk = ~i_clk;

    oriented_box_corners dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_front_x       (i_front_x),
        .i_front_y       (i_front_y),
        .i_rear_x        (i_rear_x),
        .i_rear_y        (i_rear_y),
        .i_box_width     (i_box_width),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_front_right_x (o_res[0]),
        .o_front_right_y (o_res[1]),
        .o_front_left_x  (o_res[2]),
        .o_front_left_y  (o_res[3]),
        .o_rear_left_x   (o_res[4]),
        .o_rear_left_y   (o_res[5]),
        .o_rear_right_x  (o_res[6]),
        .o_rear_right_y  (o_res[7]),
        .o_box_min_x     (o_res[8]),
        .o_box_max_x     (o_res[9]),
        .o_box_min_y     (o_res[10]),
        .o_box_max_y     (o_res[11])
    );

    // largest k <= half with (2k-1)^2 * (a^2 + b^2) <= w^2 * a^2, exact in 192 bits
    function automatic longint unsigned offset_search(longint unsigned w,
            longint unsigned half, logic [63:0] a, logic [63:0] b);
        logic [191:0]    a2;
        logic [191:0]    len2;
        logic [191:0]    m;
        longint unsigned k;
        longint unsigned c;
        a2   = 192'(a) * 192'(a);
        len2 = a2 + 192'(b) * 192'(b);
        k    = '0;
        for (int bit_i = WB - 1; bit_i >= 0; bit_i--) begin
            c = k | (64'd1 << bit_i);
            if (c <= half && (c << 1) - 64'd1 <= w) begin
                m = 192'((c << 1) - 64'd1);
                if (m * m * len2 <= 192'(w) * 192'(w) * a2) k = c;
            end
        end
        return k;
    endfunction

    function automatic logic signed [CB-1:0] clamp_coord(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[CB-1:0];
    endfunction

    function automatic t_box predict_box(logic signed [CB-1:0] fxi, fyi, rxi, ryi,
                                         logic [WB-1:0] wi);
        t_box            r;
        longint          fx, fy, rx, ry, ddx, ddy, ox, oy, fdx, fdy, rdx, rdy;
        longint unsigned adx, ady, w, half;
        fx = longint'(fxi); fy = longint'(fyi); rx = longint'(rxi); ry = longint'(ryi);
        w    = 64'(wi);
        half = (w + 64'd1) >> 1;
        ddx  = rx - fx;
        ddy  = ry - fy;
        adx  = ddx < 0 ? -ddx : ddx;
        ady  = ddy < 0 ? -ddy : ddy;
        if (adx == 0) begin
            ox = half; oy = 0;
        end else if (ady == 0) begin
            ox = 0; oy = half;
        end else begin
            ox = offset_search(w, half, ady, adx);
            oy = offset_search(w, half, adx, ady);
        end
        fdx = (ry > fy) ? -ox : ox;
        fdy = (rx < fx) ? -oy : oy;
        rdx = (fy > ry) ? -ox : ox;
        rdy = (fx < rx) ? -oy : oy;
        r.v[0] = clamp_coord(fx + fdx); r.v[1] = clamp_coord(fy + fdy);
        r.v[2] = clamp_coord(fx - fdx); r.v[3] = clamp_coord(fy - fdy);
        r.v[4] = clamp_coord(rx + rdx); r.v[5] = clamp_coord(ry + rdy);
        r.v[6] = clamp_coord(rx - rdx); r.v[7] = clamp_coord(ry - rdy);
        r.v[8] = r.v[0]; r.v[9] = r.v[0]; r.v[10] = r.v[1]; r.v[11] = r.v[1];
        for (int i = 1; i < 4; i++) begin
            if (r.v[2*i] < r.v[8]) r.v[8] = r.v[2*i];
            if (r.v[2*i] > r.v[9]) r.v[9] = r.v[2*i];
            if (r.v[2*i+1] < r.v[10]) r.v[10] = r.v[2*i+1];
            if (r.v[2*i+1] > r.v[11]) r.v[11] = r.v[2*i+1];
        end
        return r;
    endfunction

    // send one vehicle transaction, with an optional random gap before it
    task automatic send_vehicle(logic signed [CB-1:0] fx, fy, rx, ry,
                                logic [WB-1:0] w);
        int gap;
        gap = 0;
        if (sender_idle && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_front_x   <= fx;
        i_front_y   <= fy;
        i_rear_x    <= rx;
        i_rear_y    <= ry;
        i_box_width <= w;
        expected_boxes.push_back(predict_box(fx, fy, rx, ry, w));
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // check every output transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_box e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_boxes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         o_res[0]);
                n_errors++;
            end else begin
                e = expected_boxes.pop_front();
                for (int i = 0; i < 12; i++) begin
                    if (o_res[i] !== e.v[i]) begin
                        $display("%0t: field %0d expected %0d actual %0d", $time, i,
                                 e.v[i], o_res[i]);
                        n_errors++;
                    end
                end
            end
        end
    end

    // receiver stall: long hold-off when asked, else random bursts
    always @(posedge i_clk) begin
        int burst;
        if (hold_off > 0) begin
            i_out_stall <= 1'b1;
            hold_off = hold_off - 1;
        end else if (burst > 0) begin
            burst = burst - 1;
        end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 18);
            i_out_stall <= ~i_out_stall;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2000000)) - 1000000;
            2: return $urandom_range(0, 1) ? 32'sh7ffff000 + $urandom_range(0, 4095)
                                           : 32'sh80000000 + $urandom_range(0, 4095);
            default: return $signed($urandom_range(0, 64)) - 32;
        endcase
    endfunction

    task automatic test_directed();
        logic signed [CB-1:0] mx, mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        send_vehicle(0, 0, 0, 0, 0);                  // zero length, zero width
        send_vehicle(100, 200, 100, 200, 20'hfffff);  // zero length, full width
        send_vehicle(0, 0, 0, 40960, 8193);           // vertical, rear above
        send_vehicle(0, 40960, 0, 0, 8193);           // vertical, rear below
        send_vehicle(0, 0, 40960, 0, 8191);           // horizontal, rear right
        send_vehicle(40960, 0, 0, 0, 8191);           // horizontal, rear left
        send_vehicle(0, 0, 3, 4, 10);                 // diagonal, all quadrants
        send_vehicle(3, 4, 0, 0, 10);
        send_vehicle(0, 4, 3, 0, 10);
        send_vehicle(3, 0, 0, 4, 10);
        send_vehicle(mx, mx, mn, mn, 20'hfffff);      // longest vector
        send_vehicle(mn, mx, mx, mn, 20'hfffff);
        send_vehicle(mx, 0, mx, 1000, 20'hfffff);     // clamps high
        send_vehicle(mn, 0, mn, -1000, 20'hfffff);    // clamps low
        send_vehicle(0, mx, 1000, mx, 20'hfffff);
        send_vehicle(0, mn, -1000, mn, 20'hfffff);
        send_vehicle(0, 0, 1, 1, 20'hfffff);          // tiny vector, wide box
        send_vehicle(0, 0, 1, mx, 1);
        send_vehicle(-1, -1, 1, 2, 20'h55555);
        send_vehicle(32'sh55555555, 32'shaaaaaaaa, 32'shaaaaaaaa, 32'sh55555555, 20'haaaaa);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            send_vehicle(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         WB'($urandom_range(0, 3) == 0 ? $urandom_range(0, 20'hfffff)
                                                       : $urandom_range(0, 40000)));
        end
    endtask

    // hold the receiver off long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        hold_off = 80;
        test_random(60);
    endtask

    task automatic test_full_rate();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        test_random(300);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1270);
        test_backpressure();
        test_full_rate();
        i_in_valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS oriented_box_corners");
        end else begin
            $display("FAIL oriented_box_corners");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL oriented_box_corners");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/obc_pkg.sv
sv/oriented_box_corners.sv
dv/tb.sv
